### hw/rtl/sadf_pkg.sv
// sadf_pkg: shared types and codes for the slot allocator with deferred free
// no dependencies
package sadf_pkg;
  localparam int KIND_W = 2;
  localparam int SLOT_W = 5;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 3;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MARK  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FEND  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTLIVE = 2'd2;
  localparam logic [STAT_W-1:0] ST_NODIRTY = 2'd3;

  localparam logic [CFG_W-1:0] CFG_RESET = 3'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_res;
    logic              last;
  } out_item_t;
endpackage

### hw/rtl/sadf_if.sv
// sadf_if: valid/ready channel carrying one item of the given type
// no dependencies; the payload type is a parameter
interface sadf_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/sadf_out_reg.sv
// sadf_out_reg: two-entry skid buffer for result transactions
// depends on sadf_pkg, sadf_if
module sadf_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sadf_pkg::out_item_t push_data,
  output logic                space,
  sadf_if.source              out
);
  import sadf_pkg::*;
  out_item_t d0_r, d1_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic pop;

  assign pop = out.valid && out.ready;
  assign out.valid = (cnt_r != 2'd0);
  assign out.data = d0_r;
  assign space = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      d0_r <= (cnt_r == 2'd2) ? d1_r : push_data;
      if (push) d1_r <= push_data;
    end else if (push) begin
      if (cnt_r == 2'd0) d0_r <= push_data;
      else d1_r <= push_data;
    end
  end
endmodule

### hw/rtl/slot_allocator_deferred_free.sv
// Slot allocator with frame-delayed reclamation. Each transaction is processed
// sequentially: allocate for a never-used slot goes straight to the update, and
// when it pops the free stack it first reads the free-stack memory, then updates;
// release and mark need no further step. Frame end moves the slots pending for the
// frame reached one per cycle from the pending memory to the free stack memory,
// then reports the dirty slots, each read from the dirty-list memory and then
// pushed; reporting waits while the result buffer is full. Live and dirty marks
// are per-slot flip-flops cleared at reset. No clearing pass is needed.
// depends on sadf_pkg, sadf_if, sadf_out_reg
module slot_allocator_deferred_free #(
  parameter int SLOTS  = 32,
  parameter int FRAMES = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  sadf_if.sink                    in,
  sadf_if.source                  out,
  input  logic                    cfg_we,
  input  logic [sadf_pkg::CFG_W-1:0] cfg_wdata
);
  import sadf_pkg::*;
  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int PD = FRAMES * SLOTS;
  localparam int PW = $clog2(PD);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ALRD = 3'd1;
  localparam logic [2:0] S_ALWR = 3'd2;
  localparam logic [2:0] S_MOVE = 3'd3;
  localparam logic [2:0] S_DRD  = 3'd4;
  localparam logic [2:0] S_DOUT = 3'd5;

  logic [2:0] st_r;
  logic [CFG_W-1:0] cfg_r;
  logic [SLOTS-1:0] live_r, dirty_r;
  logic [CW-1:0] next_r, free_cnt_r, dirty_cnt_r, idx_r;
  logic [CW-1:0] pend_cnt_r [FRAMES];
  logic [FW-1:0] frame_r;
  logic [SW-1:0] slot_r;

  logic [SW-1:0] free_mem [SLOTS];
  logic [SW-1:0] dirty_mem [SLOTS];
  logic [SW-1:0] pend_mem [PD];
  logic [SW-1:0] free_rd, dirty_rd, pend_rd;

  logic free_we, dirty_we, pend_we;
  logic [SW-1:0] free_wa, free_ra, dirty_wa, dirty_ra, free_wd, dirty_wd, pend_wd;
  logic [PW-1:0] pend_wa, pend_ra;

  out_item_t push_data;
  logic push, space, acc;
  logic [FW:0] eff_w, fsum;
  logic [FW-1:0] frame_nxt;
  logic [SLOT_W-1:0] in_slot;
  logic in_live, mv_valid_r;

  sadf_out_reg u_out (.clk, .rst_n, .push, .push_data, .space, .out);

  assign in.ready = (st_r == S_IDLE) && space;
  assign acc = in.valid && in.ready;
  assign in_slot = in.data.slot;
  assign in_live = ({{(32-SLOT_W){1'b0}}, in_slot} < SLOTS) && (in_slot != '0)
                   && live_r[in_slot[SW-1:0]];

  // next frame index modulo the frames in use
  always_comb begin
    if (cfg_r == '0) eff_w = (FW+1)'(1);
    else if ({29'd0, cfg_r} > FRAMES) eff_w = (FW+1)'(FRAMES);
    else eff_w = (FW+1)'(cfg_r);
    fsum = {1'b0, frame_r} + (FW+1)'(1);
    for (int i = 0; i < FRAMES; i++) begin
      if (fsum >= eff_w) fsum = fsum - eff_w;
    end
    frame_nxt = fsum[FW-1:0];
  end

  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    free_rd <= free_mem[free_ra];
    if (dirty_we) dirty_mem[dirty_wa] <= dirty_wd;
    dirty_rd <= dirty_mem[dirty_ra];
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    pend_rd <= pend_mem[pend_ra];
  end

  always_comb begin
    free_ra = SW'(free_cnt_r - CW'(1));
    dirty_ra = idx_r[SW-1:0];
    pend_ra = PW'(frame_r * SLOTS + idx_r);
    free_we = 1'b0; free_wa = free_cnt_r[SW-1:0]; free_wd = pend_rd;
    dirty_we = 1'b0; dirty_wa = dirty_cnt_r[SW-1:0]; dirty_wd = slot_r;
    pend_we = 1'b0;
    pend_wa = PW'(frame_r * SLOTS + pend_cnt_r[frame_r]);
    pend_wd = in_slot[SW-1:0];
    push = 1'b0;
    push_data = '{status: ST_OK, slot_res: '0, last: 1'b1};
    if (st_r == S_IDLE && acc) begin
      unique case (in.data.kind)
        KIND_ALLOC: begin
          if (free_cnt_r == '0 && next_r >= CW'(SLOTS)) begin
            push = 1'b1;
            push_data.status = ST_FULL;
          end
        end
        KIND_REL: begin
          push = 1'b1;
          push_data.slot_res = in_slot;
          if (!in_live) push_data.status = ST_NOTLIVE;
          else pend_we = (pend_cnt_r[frame_r] < CW'(SLOTS));
        end
        KIND_MARK: begin
          push = 1'b1;
          push_data.slot_res = in_slot;
          if (!in_live) push_data.status = ST_NOTLIVE;
          else if (!dirty_r[in_slot[SW-1:0]] && dirty_cnt_r < CW'(SLOTS)) begin
            dirty_we = 1'b1;
            dirty_wd = in_slot[SW-1:0];
          end
        end
        default: ;
      endcase
    end
    if (st_r == S_ALWR) begin
      push = 1'b1;
      push_data.slot_res = SLOT_W'(slot_r);
      dirty_we = !dirty_r[slot_r] && dirty_cnt_r < CW'(SLOTS);
    end
    if (st_r == S_MOVE && mv_valid_r) begin
      free_we = (free_cnt_r < CW'(SLOTS));
    end
    if (st_r == S_DRD && dirty_cnt_r == '0 && space) begin
      push = 1'b1;
      push_data.status = ST_NODIRTY;
    end
    if (st_r == S_DOUT) begin
      push = 1'b1;
      push_data.slot_res = SLOT_W'(dirty_rd);
      push_data.last = (idx_r == dirty_cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cfg_r <= CFG_RESET;
      live_r <= '0;
      dirty_r <= '0;
      next_r <= CW'(1);
      free_cnt_r <= '0;
      dirty_cnt_r <= '0;
      frame_r <= '0;
      idx_r <= '0;
      mv_valid_r <= 1'b0;
      for (int i = 0; i < FRAMES; i++) pend_cnt_r[i] <= '0;
    end else begin
      if (cfg_we) cfg_r <= cfg_wdata;
      if (dirty_we) dirty_cnt_r <= dirty_cnt_r + CW'(1);
      unique case (st_r)
        S_IDLE: begin
          if (acc) begin
            unique case (in.data.kind)
              KIND_ALLOC: begin
                if (free_cnt_r != '0) begin
                  st_r <= S_ALRD;
                  free_cnt_r <= free_cnt_r - CW'(1);
                end else if (next_r < CW'(SLOTS)) begin
                  slot_r <= next_r[SW-1:0];
                  next_r <= next_r + CW'(1);
                  st_r <= S_ALWR;
                end
              end
              KIND_REL: begin
                if (in_live) begin
                  live_r[in_slot[SW-1:0]] <= 1'b0;
                  dirty_r[in_slot[SW-1:0]] <= 1'b0;
                  if (pend_we) pend_cnt_r[frame_r] <= pend_cnt_r[frame_r] + CW'(1);
                end
              end
              KIND_MARK: begin
                if (in_live) dirty_r[in_slot[SW-1:0]] <= 1'b1;
              end
              default: begin
                frame_r <= frame_nxt;
                idx_r <= '0;
                mv_valid_r <= 1'b0;
                st_r <= S_MOVE;
              end
            endcase
          end
        end
        S_ALRD: begin
          slot_r <= free_rd;
          st_r <= S_ALWR;
        end
        S_ALWR: begin
          live_r[slot_r] <= 1'b1;
          dirty_r[slot_r] <= 1'b1;
          st_r <= S_IDLE;
        end
        S_MOVE: begin
          if (free_we) free_cnt_r <= free_cnt_r + CW'(1);
          if (idx_r < pend_cnt_r[frame_r]) begin
            idx_r <= idx_r + CW'(1);
            mv_valid_r <= 1'b1;
          end else begin
            pend_cnt_r[frame_r] <= '0;
            mv_valid_r <= 1'b0;
            idx_r <= '0;
            dirty_r <= '0;
            st_r <= S_DRD;
          end
        end
        S_DRD: begin
          if (dirty_cnt_r == '0) begin
            if (space) st_r <= S_IDLE;
          end else if (space) begin
            idx_r <= idx_r + CW'(1);
            st_r <= S_DOUT;
          end
        end
        default: begin
          if (idx_r == dirty_cnt_r) begin
            dirty_cnt_r <= '0;
            st_r <= S_IDLE;
          end else begin
            st_r <= S_DRD;
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in.ready |-> st_r == S_IDLE) else $error("ready outside idle");
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= CW'(SLOTS)) else $error("free count overflow");
  a_dirty_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dirty_cnt_r <= CW'(SLOTS)) else $error("dirty count overflow");
  a_alloc_live: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_ALWR |=> live_r[$past(slot_r)]) else $error("alloc not live");
`endif
endmodule
